// ----- hdl/cfb_pkg.sv -----
// Shared constants, types and the CRC byte update for the command frame builder.
package cfb_pkg;

  localparam logic [7:0]  FRAME_HEADER = 8'h3A;
  localparam logic [7:0]  TRAILER_CR   = 8'h0D;
  localparam logic [7:0]  TRAILER_LF   = 8'h0A;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;

  // Control for the running CRC register, driven by the byte sequencer.
  typedef struct packed {
    logic       update;
    logic       restart;
    logic [7:0] data;
  } crc_ctl_t;

  // One byte of the reflected CRC-16, one bit per iteration.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data_in);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data_in};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// ----- hdl/cfb_crc16.sv -----
// Running CRC-16 register that folds in each covered byte as it is emitted.
module cfb_crc16 (
  input  logic              clk,
  input  logic              rst,
  input  cfb_pkg::crc_ctl_t ctl,
  output logic [15:0]       crc
);
  import cfb_pkg::*;

  logic [15:0] crc_base;

  // A header byte starts a fresh CRC; every other covered byte continues it.
  assign crc_base = ctl.restart ? CRC_INIT : crc;

  // Fold the emitted byte into the running value.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_INIT;
    end else if (ctl.update) begin
      crc <= crc_byte(crc_base, ctl.data);
    end
  end

endmodule

// ----- hdl/command_frame_builder_crc16_top.sv -----
// Command frame builder: input item register, byte sequencer and output byte register.
//
// Each input beat carries one payload byte. The output channel delivers one framed byte
// per cycle, while out_ready allows, from a single output register, which sets the pace:
// a middle payload byte goes out alone, the first byte of a frame goes out as four bytes
// (header 0x3A, length plus one, command code, then the byte), and the last byte is
// followed by four more bytes (CRC high byte, CRC low byte, 0x0D, 0x0A, with end_of_frame
// on the 0x0A). A single-byte frame is thus eight bytes. The CRC-16 (init 0xFFFF, reflected
// polynomial 0xA001, no final xor) covers header, length, command and payload. A new
// input beat is taken in the same cycle that the previous item's final byte moves into
// the output register, so a stream of middle bytes runs at one per cycle unless the output
// stalls. There is no empty-frame form, and the length byte is carried as a label only.
module command_frame_builder_crc16_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] command_code,
  input  logic [7:0] length_value,
  input  logic [7:0] payload_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       end_of_frame
);
  import cfb_pkg::*;

  // Sequencer phases: which byte of the item goes out next.
  localparam logic [2:0] PH_HDR  = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_CMD  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CRCH = 3'd4;
  localparam logic [2:0] PH_CRCL = 3'd5;
  localparam logic [2:0] PH_CR   = 3'd6;
  localparam logic [2:0] PH_LF   = 3'd7;

  logic       busy;
  logic       in_frame;
  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [7:0] cmd_r;
  logic [7:0] len_r;
  logic [7:0] dat_r;
  logic       last_r;

  logic       load_en;
  logic       item_done;
  logic       accept;
  logic [7:0] emit_byte;
  logic       emit_eof;
  logic       emit_crc;

  logic [15:0] crc;
  crc_ctl_t    crc_ctl;

  // With an item held, the output register takes a byte whenever it is empty or draining.
  assign load_en   = busy && (!out_valid || out_ready);
  assign item_done = load_en && (((phase == PH_DATA) && !last_r) || (phase == PH_LF));
  assign in_ready  = !busy || item_done;
  assign accept    = in_valid && in_ready;

  // Select the byte for the current phase and the phase that follows it.
  always_comb begin
    emit_byte  = dat_r;
    emit_eof   = 1'b0;
    emit_crc   = 1'b0;
    phase_next = PH_HDR;
    case (phase)
      PH_HDR: begin
        emit_byte  = FRAME_HEADER;
        emit_crc   = 1'b1;
        phase_next = PH_LEN;
      end
      PH_LEN: begin
        emit_byte  = len_r + 8'd1;
        emit_crc   = 1'b1;
        phase_next = PH_CMD;
      end
      PH_CMD: begin
        emit_byte  = cmd_r;
        emit_crc   = 1'b1;
        phase_next = PH_DATA;
      end
      PH_DATA: begin
        emit_byte  = dat_r;
        emit_crc   = 1'b1;
        phase_next = last_r ? PH_CRCH : PH_HDR;
      end
      PH_CRCH: begin
        emit_byte  = crc[15:8];
        phase_next = PH_CRCL;
      end
      PH_CRCL: begin
        emit_byte  = crc[7:0];
        phase_next = PH_CR;
      end
      PH_CR: begin
        emit_byte  = TRAILER_CR;
        phase_next = PH_LF;
      end
      PH_LF: begin
        emit_byte  = TRAILER_LF;
        emit_eof   = 1'b1;
        phase_next = PH_HDR;
      end
      default: begin
        emit_byte  = dat_r;
        phase_next = PH_HDR;
      end
    endcase
  end

  // The CRC advances on every covered byte as it enters the output register.
  always_comb begin
    crc_ctl.update  = load_en && emit_crc;
    crc_ctl.restart = (phase == PH_HDR);
    crc_ctl.data    = emit_byte;
  end

  cfb_crc16 u_crc (
    .clk (clk),
    .rst (rst),
    .ctl (crc_ctl),
    .crc (crc)
  );

  // Control state: item occupancy, frame state, phase and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      in_frame  <= 1'b0;
      phase     <= PH_HDR;
      out_valid <= 1'b0;
    end else begin
      if (load_en) begin
        phase <= phase_next;
      end
      if (item_done) begin
        busy <= 1'b0;
      end
      if (accept) begin
        busy     <= 1'b1;
        phase    <= in_frame ? PH_DATA : PH_HDR;
        in_frame <= !last_byte;
      end
      if (load_en) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: the accepted input beat and the byte on the output.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= command_code;
      len_r  <= length_value;
      dat_r  <= payload_byte;
      last_r <= last_byte;
    end
    if (load_en) begin
      out_byte     <= emit_byte;
      end_of_frame <= emit_eof;
    end
  end

endmodule
